// ===== rtl/rgc_pkg.sv =====
// Shared types and constants for the row gray-centroid line center block.
package rgc_pkg;

    localparam int CFG_W  = 11;
    localparam int PIX_W  = 8;
    localparam int OUT_W  = 10;
    localparam int IDX_W  = 2;
    localparam int PIX_MAX = 255;

    localparam logic [IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [CFG_W-1:0] RST_ROW_WIDTH    = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [PIX_W-1:0] RST_THRESHOLD    = 8'd30;

    typedef struct packed {
        logic [CFG_W-1:0] row_width;
        logic [CFG_W-1:0] image_height;
        logic [PIX_W-1:0] threshold;
    } t_cfg;

endpackage

// ===== rtl/row_gray_centroid_line_center.sv =====
// Top level of the row gray-centroid line center block.
// Accepts one gray pixel per clock in raster order while the input is ready.
// Pixels strictly above the threshold add to an intensity sum and a
// column-weighted sum; at each row end the sums go to a two-entry queue and
// a restoring divider produces the center column one quotient bit at a time,
// one for each bit of the column index, then hands it to the registered
// result output. The pixel input sees no stall while the queue has room; with
// short rows, or while the receiver holds off, the input holds off at the
// last pixel of a row once the queue is full. A row with no bright pixel
// reports line_found = 0 and center column 0. The user must write
// configuration only while the block is idle; the block does not enforce it.
module row_gray_centroid_line_center #(
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int MAX_ROWS      = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [rgc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [rgc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rgc_pkg::PIX_W-1:0]  i_gray_pixel,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rgc_pkg::OUT_W-1:0]  o_row_index,
    output logic [rgc_pkg::OUT_W-1:0]  o_center_column,
    output logic                       o_line_found,
    output logic                       o_frame_end
);
    import rgc_pkg::*;

    localparam int CW  = $clog2(MAX_ROW_WIDTH);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ISW = $clog2(PIX_MAX * MAX_ROW_WIDTH + 1);
    localparam longint unsigned WMAX = longint'(PIX_MAX) * longint'(MAX_ROW_WIDTH)
                                       * longint'(MAX_ROW_WIDTH - 1) / 2;
    localparam int WSW = $clog2(WMAX + 1);
    localparam int QW  = OUT_W + 1 + ISW + WSW;

    t_cfg             r_cfg;

    logic             w_row_end;
    logic             w_push;
    logic             w_push_ready;
    logic [OUT_W-1:0] f_row;
    logic             f_last;
    logic [ISW-1:0]   f_isum;
    logic [WSW-1:0]   f_wsum;
    logic [QW-1:0]    q_in;
    logic [QW-1:0]    q_out;
    logic             q_valid;
    logic             q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width    <= RST_ROW_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.threshold    <= RST_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ROW_WIDTH:    r_cfg.row_width    <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                REG_THRESHOLD:    r_cfg.threshold    <= i_cfg_data[PIX_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    rgc_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .MAX_ROWS      (MAX_ROWS),
        .CW            (CW),
        .RW            (RW),
        .ISW           (ISW),
        .WSW           (WSW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .i_gray_pixel (i_gray_pixel),
        .o_ready      (o_in_ready),
        .o_row_end    (w_row_end),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_row_index  (f_row),
        .o_frame_end  (f_last),
        .o_isum       (f_isum),
        .o_wsum       (f_wsum)
    );

    assign q_in = {f_row, f_last, f_isum, f_wsum};

    rgc_fifo #(
        .DATA_W (QW)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (q_in),
        .o_in_ready (w_push_ready),
        .o_valid    (q_valid),
        .i_pop      (q_pop),
        .o_data     (q_out)
    );

    rgc_back #(
        .CW  (CW),
        .ISW (ISW),
        .WSW (WSW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_row_index     (q_out[QW-1 -: OUT_W]),
        .i_frame_end     (q_out[ISW+WSW]),
        .i_isum          (q_out[ISW+WSW-1 -: ISW]),
        .i_wsum          (q_out[WSW-1:0]),
        .o_pop           (q_pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_row_index     (o_row_index),
        .o_center_column (o_center_column),
        .o_line_found    (o_line_found),
        .o_frame_end     (o_frame_end)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_push_ready)
        else $error("row sum pushed into full queue");

    a_stall_only_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_row_end)
        else $error("pixel input stalled mid-row");

    a_no_line_zero_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_line_found) |-> (o_center_column == '0))
        else $error("nonzero center reported for row without line");

    a_pop_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("divider took row sums from empty queue");

endmodule

// ===== rtl/rgc_front.sv =====
// Front end: pixel accumulation, column/row tracking, row-end push to queue.
module rgc_front #(
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int MAX_ROWS      = 1024,
    parameter int CW            = 10,
    parameter int RW            = 10,
    parameter int ISW           = 18,
    parameter int WSW           = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rgc_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    input  logic [rgc_pkg::PIX_W-1:0]  i_gray_pixel,
    output logic                       o_ready,
    output logic                       o_row_end,
    output logic                       o_push,
    input  logic                       i_push_ready,
    output logic [rgc_pkg::OUT_W-1:0]  o_row_index,
    output logic                       o_frame_end,
    output logic [ISW-1:0]             o_isum,
    output logic [WSW-1:0]             o_wsum
);
    import rgc_pkg::*;

    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [ISW-1:0]       r_isum;
    logic [WSW-1:0]       r_wsum;

    logic [CW:0]          w_eff;
    logic [RW:0]          h_eff;
    logic [CW:0]          col_inc;
    logic [RW:0]          row_inc;
    logic                 hit;
    logic                 accept;
    logic [PIX_W+CW-1:0]  prod;
    logic [ISW-1:0]       n_isum;
    logic [WSW-1:0]       n_wsum;
    logic [31:0]          row32;

    always_comb begin
        if (i_cfg.row_width == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(i_cfg.row_width) > MAX_ROW_WIDTH) begin
            w_eff = (CW+1)'(MAX_ROW_WIDTH);
        end else begin
            w_eff = (CW+1)'(i_cfg.row_width);
        end
        if (i_cfg.image_height == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(i_cfg.image_height) > MAX_ROWS) begin
            h_eff = (RW+1)'(MAX_ROWS);
        end else begin
            h_eff = (RW+1)'(i_cfg.image_height);
        end
        col_inc     = (CW+1)'(r_col) + (CW+1)'(1);
        row_inc     = (RW+1)'(r_row) + (RW+1)'(1);
        o_row_end   = !(col_inc < w_eff);
        o_frame_end = (row_inc >= h_eff);
        hit         = (i_gray_pixel > i_cfg.threshold);
        prod        = (PIX_W+CW)'(i_gray_pixel) * (PIX_W+CW)'(r_col);
        n_isum      = hit ? (r_isum + ISW'(i_gray_pixel)) : r_isum;
        n_wsum      = hit ? (r_wsum + WSW'(prod)) : r_wsum;
        row32       = 32'(r_row);
        o_row_index = row32[OUT_W-1:0];
    end

    assign o_ready = i_push_ready || !o_row_end;
    assign accept  = i_valid && o_ready;
    assign o_push  = i_valid && o_row_end && i_push_ready;
    assign o_isum  = n_isum;
    assign o_wsum  = n_wsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_isum <= '0;
            r_wsum <= '0;
        end else if (accept) begin
            if (o_row_end) begin
                r_col  <= '0;
                r_isum <= '0;
                r_wsum <= '0;
                r_row  <= o_frame_end ? '0 : RW'(row_inc);
            end else begin
                r_col  <= CW'(col_inc);
                r_isum <= n_isum;
                r_wsum <= n_wsum;
            end
        end
    end

endmodule

// ===== rtl/rgc_fifo.sv =====
// Two-entry queue of finished row sums between front and back end.
module rgc_fifo #(
    parameter int DATA_W = 57
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    localparam int DEPTH = 2;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_in_ready = (r_cnt != 2'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/rgc_back.sv =====
// Back end: iterative restoring divider and registered result output.
module rgc_back #(
    parameter int CW  = 10,
    parameter int ISW = 18,
    parameter int WSW = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rgc_pkg::OUT_W-1:0]  i_row_index,
    input  logic                       i_frame_end,
    input  logic [ISW-1:0]             i_isum,
    input  logic [WSW-1:0]             i_wsum,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rgc_pkg::OUT_W-1:0]  o_row_index,
    output logic [rgc_pkg::OUT_W-1:0]  o_center_column,
    output logic                       o_line_found,
    output logic                       o_frame_end
);
    import rgc_pkg::*;

    localparam int CNW = (CW > 1) ? $clog2(CW) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [OUT_W-1:0] r_row;
    logic             r_last;
    logic             r_found;
    logic [ISW-1:0]   r_div;
    logic [ISW-1:0]   r_rem;
    logic [CW-1:0]    r_quo;
    logic [CNW-1:0]   r_cnt;

    logic [ISW:0]     trial;
    logic [ISW:0]     diff;
    logic             ge;
    logic [ISW-1:0]   n_rem;
    logic [CW-1:0]    n_quo;
    logic [31:0]      quo32;
    logic             out_free;

    always_comb begin
        trial    = {r_rem, r_quo[CW-1]};
        ge       = (trial >= {1'b0, r_div});
        diff     = trial - {1'b0, r_div};
        n_rem    = ge ? ISW'(diff) : ISW'(trial);
        n_quo    = CW'({r_quo, ge});
        quo32    = 32'(r_quo);
        out_free = !o_valid || i_ready;
    end

    assign o_pop = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_row   <= i_row_index;
                        r_last  <= i_frame_end;
                        r_div   <= i_isum;
                        r_rem   <= ISW'(i_wsum >> CW);
                        r_quo   <= (i_isum == '0) ? '0 : CW'(i_wsum);
                        r_cnt   <= CNW'(CW - 1);
                        r_found <= (i_isum != '0);
                        if (i_isum == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid         <= 1'b1;
                        o_row_index     <= r_row;
                        o_center_column <= quo32[OUT_W-1:0];
                        o_line_found    <= r_found;
                        o_frame_end     <= r_last;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== test/line_center_checker.sv =====
// Checker for the row gray-centroid block: tracks rows, predicts each row result, compares.
module line_center_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [rgc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [rgc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [rgc_pkg::PIX_W-1:0]  i_gray_pixel,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [rgc_pkg::OUT_W-1:0]  i_row_index,
    input  logic [rgc_pkg::OUT_W-1:0]  i_center_column,
    input  logic                       i_line_found,
    input  logic                       i_frame_end,
    output int                         o_mismatches,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgc_pkg::*;

    localparam int unsigned WIDTH_CAP  = 1024;
    localparam int unsigned HEIGHT_CAP = 1024;

    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] center;
        logic             found;
        logic             last_row;
    } t_row_center;

    t_cfg          cfg;
    int unsigned   col_count;
    int unsigned   row_count;
    logic [17:0]   bright_sum;
    logic [27:0]   moment_sum;
    t_row_center   expected_rows[$];
    int            mismatch_count = 0;
    int            pending_rows = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_rows;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned limit);
        if (v == '0)
            return 1;
        if (32'(v) > limit)
            return limit;
        return 32'(v);
    endfunction

    task automatic accumulate_pixel(input logic [PIX_W-1:0] pix);
        int unsigned width;
        int unsigned height;
        logic [27:0] quotient;
        t_row_center r;
        width  = clamp_dim(cfg.row_width, WIDTH_CAP);
        height = clamp_dim(cfg.image_height, HEIGHT_CAP);
        if (pix > cfg.threshold) begin
            bright_sum += pix;
            moment_sum += pix * col_count;
        end
        if (col_count + 1 < width) begin
            col_count++;
        end else begin
            r.row      = row_count[OUT_W-1:0];
            r.found    = (bright_sum != '0);
            quotient   = r.found ? moment_sum / bright_sum : '0;
            r.center   = quotient[OUT_W-1:0];
            r.last_row = (row_count + 1 >= height);
            expected_rows.push_back(r);
            col_count  = 0;
            bright_sum = '0;
            moment_sum = '0;
            row_count  = r.last_row ? 0 : row_count + 1;
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_row_center want;
        if (!i_rst_n) begin
            cfg.row_width    = RST_ROW_WIDTH;
            cfg.image_height = RST_IMAGE_HEIGHT;
            cfg.threshold    = RST_THRESHOLD;
            col_count        = 0;
            row_count        = 0;
            bright_sum       = '0;
            moment_sum       = '0;
            expected_rows.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row result, expected none, actual row %0d col %0d",
                             $time, i_row_index, i_center_column);
                    mismatch_count++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("row_index", want.row, i_row_index);
                    check_field("center_column", want.center, i_center_column);
                    check_field("line_found", want.found, i_line_found);
                    check_field("frame_end", want.last_row, i_frame_end);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_ROW_WIDTH:    cfg.row_width    = i_cfg_data;
                    REG_IMAGE_HEIGHT: cfg.image_height = i_cfg_data;
                    REG_THRESHOLD:    cfg.threshold    = i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                accumulate_pixel(i_gray_pixel);
        end
        pending_rows = expected_rows.size();
    end

endmodule

// ===== test/tb_row_gray_centroid_line_center.sv =====
// Testbench top for the row gray-centroid line center block: stimulus, flow control, verdict.
module tb_row_gray_centroid_line_center;
    timeunit 1ns;
    timeprecision 1ps;
    import rgc_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PIXELS = 350;
    localparam int LONG_ROW      = 160;
    localparam int TALL_PIXELS   = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [PIX_W-1:0]  i_gray_pixel = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [OUT_W-1:0]  o_row_index;
    logic [OUT_W-1:0]  o_center_column;
    logic              o_line_found;
    logic              o_frame_end;

    int               mismatches;
    int               outstanding;
    int               quiet_cycles = 0;
    int               pixels_sent = 0;
    bit               tx_gaps_on = 1'b0;
    bit               rx_gaps_on = 1'b0;
    bit               rx_hold_req = 1'b0;
    logic [PIX_W-1:0] cur_thr = RST_THRESHOLD;

    always #2 i_clk = ~i_clk;

    row_gray_centroid_line_center uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_gray_pixel    (i_gray_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_row_index     (o_row_index),
        .o_center_column (o_center_column),
        .o_line_found    (o_line_found),
        .o_frame_end     (o_frame_end)
    );

    line_center_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_gray_pixel    (i_gray_pixel),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_row_index     (o_row_index),
        .i_center_column (o_center_column),
        .i_line_found    (o_line_found),
        .i_frame_end     (o_frame_end),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result receiver
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left  = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        @(negedge i_clk);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_gray_pixel <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == REG_THRESHOLD)
            cur_thr = data[PIX_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // hold off until every row result is back and the divider has settled
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic start_phase(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                               input logic [CFG_W-1:0] thr_data);
        wait_idle();
        cfg_write(REG_ROW_WIDTH, width);
        cfg_write(REG_IMAGE_HEIGHT, height);
        cfg_write(REG_THRESHOLD, thr_data);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int bright_pct);
        if (cur_thr != PIX_MAX && $urandom_range(0, 99) < bright_pct)
            return PIX_W'($urandom_range(int'(cur_thr) + 1, PIX_MAX));
        return PIX_W'($urandom_range(0, int'(cur_thr)));
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(9, 64));
            2:       return CFG_W'($urandom_range(1025, 2047));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        int bright_pct;
        int count;
        logic [PIX_W-1:0] thr;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        // reset settings, row left open at column 5
        send_pixel(8'd30);
        send_pixel(8'd31);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd29);
        // width shrunk below current column: next pixel closes the row
        wait_idle();
        cfg_write(REG_ROW_WIDTH, 11'd4);
        cfg_write(REG_IMAGE_HEIGHT, 11'd2);
        send_pixel(8'd100);
        send_pixel(8'd0);
        send_pixel(8'd30);
        send_pixel(8'd30);
        send_pixel(8'd0);
        // threshold 0, one-pixel rows, one-row frames
        start_phase(11'd1, 11'd1, 11'd0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd255);
        // threshold 255: nothing is bright; width 0 acts as 1
        start_phase(11'd2, 11'd1, 11'd255);
        send_pixel(8'd255);
        send_pixel(8'd255);
        wait_idle();
        cfg_write(REG_ROW_WIDTH, 11'd0);
        send_pixel(8'd200);
        wait_idle();
        cfg_write(REG_THRESHOLD, 11'd254);
        cfg_write(REG_UNUSED, 11'd0);
        send_pixel(8'd255);
        // height shrunk mid-frame
        start_phase(11'd1, 11'd5, 11'd254);
        send_pixel(8'd255);
        send_pixel(8'd7);
        send_pixel(8'd254);
        wait_idle();
        cfg_write(REG_IMAGE_HEIGHT, 11'd2);
        send_pixel(8'd255);

        // long rows: lone bright pixel in the last column, then a saturated row
        start_phase(CFG_W'(LONG_ROW), 11'd4, 11'd254);
        for (int c = 0; c < LONG_ROW; c++)
            send_pixel(c == LONG_ROW - 1 ? 8'd255 : 8'd0);
        for (int c = 0; c < LONG_ROW; c++)
            send_pixel(8'd255);

        // tall frame with one-pixel rows; receiver holds off long at the start
        start_phase(11'd0, 11'd2047, CFG_W'($urandom_range(0, 2047)));
        rx_hold_req = 1'b1;
        for (int i = 0; i < TALL_PIXELS; i++)
            send_pixel(pick_pixel(50));

        count = 0;
        while (count < RANDOM_PIXELS) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       thr = '0;
                1:       thr = '1;
                default: thr = PIX_W'($urandom);
            endcase
            start_phase(pick_size(), pick_size(), {3'($urandom), thr});
            if ($urandom_range(0, 4) == 0)
                cfg_write(REG_UNUSED, CFG_W'($urandom));
            bright_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 100);
            for (int i = $urandom_range(10, 50); i > 0; i--) begin
                send_pixel(pick_pixel(bright_pct));
                count++;
            end
        end

        // last stretch at full rate on both sides
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        start_phase(11'd5, 11'd3, 11'd64);
        for (int i = 0; i < 60; i++)
            send_pixel(pick_pixel(40));

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rgc_pkg.sv
rtl/rgc_front.sv
rtl/rgc_fifo.sv
rtl/rgc_back.sv
rtl/row_gray_centroid_line_center.sv
test/line_center_checker.sv
test/tb_row_gray_centroid_line_center.sv
